[sv/sle_pkg.sv]
package sle_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_CLEAR  = 3'd0;
    localparam op_t OP_INSERT = 3'd1;
    localparam op_t OP_DELETE = 3'd2;
    localparam op_t OP_GET    = 3'd3;
    localparam op_t OP_LOCATE = 3'd4;
    localparam op_t OP_PRIOR  = 3'd5;
    localparam op_t OP_NEXT   = 3'd6;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 7;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data_out;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  length;
        logic              empty_res;
    } sle_res_t;

endpackage

[sv/sle_ram.sv]
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/sle_core.sv]
module sle_core #(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  sle_pkg::op_t                op,
    input  logic [sle_pkg::IDX_W-1:0]   idx,
    input  logic [sle_pkg::DATA_W-1:0]  value,
    output logic                        idle,
    output logic                        ram_we,
    output logic [$clog2(DEPTH)-1:0]    ram_waddr,
    output logic [ELEMENT_WIDTH-1:0]    ram_wdata,
    output logic [$clog2(DEPTH)-1:0]    ram_raddr,
    input  logic [ELEMENT_WIDTH-1:0]    ram_rdata,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sle_pkg::sle_res_t           res
);

    localparam int AW  = $clog2(DEPTH);
    localparam int LW  = $clog2(DEPTH + 1);
    localparam int CW  = (LW > sle_pkg::IDX_W) ? LW : sle_pkg::IDX_W;
    localparam int DW  = (ELEMENT_WIDTH > sle_pkg::DATA_W) ? ELEMENT_WIDTH : sle_pkg::DATA_W;
    localparam int PW  = (AW > sle_pkg::POS_W) ? AW : sle_pkg::POS_W;
    localparam int LXW = (LW > sle_pkg::LEN_W) ? LW : sle_pkg::LEN_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PUTV = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [LW-1:0]               len_reg, len_next;
    sle_pkg::op_t                op_reg, op_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [ELEMENT_WIDTH-1:0]    val_reg, val_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    logic [LW-1:0]               cnt_reg, cnt_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               paddr_reg, paddr_next;
    logic                        found_reg, found_next;
    logic [ELEMENT_WIDTH-1:0]    prev_reg, prev_next;
    logic                        ok_reg, ok_next;
    logic [sle_pkg::DATA_W-1:0]  data_reg, data_next;
    logic [AW-1:0]               pos_reg, pos_next;

    logic [CW-1:0]               idx_ext, len_ext;
    logic [LW-1:0]               len_m1;
    logic [DW-1:0]               rd_wide, prev_wide, val_wide;
    logic [PW-1:0]               pos_wide;
    logic [LXW-1:0]              len_wide;
    logic                        issue;

    assign idx_ext   = CW'(idx);
    assign len_ext   = CW'(len_reg);
    assign len_m1    = len_reg - LW'(1);
    assign rd_wide   = DW'(ram_rdata);
    assign prev_wide = DW'(prev_reg);
    assign val_wide  = DW'(value);
    assign pos_wide  = PW'(pos_reg);
    assign len_wide  = LXW'(len_reg);
    assign issue     = (cnt_reg != '0) && !found_reg;

    assign idle          = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_FIN);
    assign res.ok        = ok_reg;
    assign res.data_out  = data_reg;
    assign res.position  = pos_wide[sle_pkg::POS_W-1:0];
    assign res.length    = len_wide[sle_pkg::LEN_W-1:0];
    assign res.empty_res = (len_reg == '0);

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        paddr_next = ptr_reg;
        found_next = found_reg;
        prev_next  = prev_reg;
        ok_next    = ok_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        ram_we     = 1'b0;
        ram_waddr  = paddr_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = ptr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_next    = op;
                    idx_next   = idx_ext[AW-1:0];
                    val_next   = val_wide[ELEMENT_WIDTH-1:0];
                    ok_next    = 1'b0;
                    data_next  = '0;
                    pos_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_FIN;
                    unique case (op) inside
                        sle_pkg::OP_CLEAR: begin
                            len_next = '0;
                            ok_next  = 1'b1;
                        end
                        sle_pkg::OP_INSERT: begin
                            if (len_ext < CW'(DEPTH) && idx_ext <= len_ext) begin
                                ptr_next   = len_m1[AW-1:0];
                                cnt_next   = LW'(len_ext - idx_ext);
                                state_next = ST_SCAN;
                            end
                        end
                        sle_pkg::OP_DELETE, sle_pkg::OP_GET: begin
                            if (idx_ext < len_ext) begin
                                ptr_next   = idx_ext[AW-1:0];
                                cnt_next   = (op == sle_pkg::OP_DELETE)
                                           ? LW'(len_ext - idx_ext) : LW'(1);
                                state_next = ST_SCAN;
                            end
                        end
                        sle_pkg::OP_LOCATE, sle_pkg::OP_PRIOR, sle_pkg::OP_NEXT: begin
                            ptr_next   = '0;
                            cnt_next   = len_reg;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    cnt_next   = cnt_reg - LW'(1);
                    ptr_next   = (op_reg == sle_pkg::OP_INSERT)
                               ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                end
                if (pend_reg) begin
                    unique case (op_reg)
                        sle_pkg::OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = paddr_reg + AW'(1);
                        end
                        sle_pkg::OP_DELETE: begin
                            if (paddr_reg == idx_reg) begin
                                data_next = rd_wide[sle_pkg::DATA_W-1:0];
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = paddr_reg - AW'(1);
                            end
                        end
                        sle_pkg::OP_GET: begin
                            data_next = rd_wide[sle_pkg::DATA_W-1:0];
                            ok_next   = 1'b1;
                        end
                        default: begin
                            if (found_reg) begin
                                // element after the match
                                if (op_reg == sle_pkg::OP_NEXT) begin
                                    data_next = rd_wide[sle_pkg::DATA_W-1:0];
                                    ok_next   = 1'b1;
                                end
                            end else if (ram_rdata == val_reg) begin
                                found_next = 1'b1;
                                if (op_reg == sle_pkg::OP_LOCATE) begin
                                    ok_next  = 1'b1;
                                    pos_next = paddr_reg;
                                end else if (op_reg == sle_pkg::OP_PRIOR
                                             && paddr_reg != '0) begin
                                    ok_next   = 1'b1;
                                    data_next = prev_wide[sle_pkg::DATA_W-1:0];
                                end
                            end else begin
                                prev_next = ram_rdata;
                            end
                        end
                    endcase
                end
                if (!issue && !pend_reg) begin
                    if (op_reg == sle_pkg::OP_INSERT) begin
                        state_next = ST_PUTV;
                    end else begin
                        if (op_reg == sle_pkg::OP_DELETE) begin
                            len_next = len_reg - LW'(1);
                            ok_next  = 1'b1;
                        end
                        state_next = ST_FIN;
                    end
                end
            end
            ST_PUTV: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = val_reg;
                len_next   = len_reg + LW'(1);
                ok_next    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        ptr_reg   <= ptr_next;
        paddr_reg <= paddr_next;
        prev_reg  <= prev_next;
        ok_reg    <= ok_next;
        data_reg  <= data_next;
        pos_reg   <= pos_next;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(DEPTH))
        else $error("list length beyond capacity");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> state_reg != ST_IDLE)
        else $error("accepted item left the sequencer idle");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && ram_we && issue) |-> ram_waddr != ram_raddr)
        else $error("shift write hits the address being read");

    a_putv_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PUTV |-> $past(state_reg) == ST_SCAN && op_reg == sle_pkg::OP_INSERT)
        else $error("value write outside an insert");

endmodule

[sv/sequential_list_engine.sv]
// bounded ordered list of up to DEPTH signed entries held in a single-port-write ram; one
// request is taken at a time and s_tready stays low until its result is in the output
// register. insert and delete shift the entries between the index and the end of the
// list, and locate, prior and next search it from the front; the shift or search walk
// moves or compares one entry per cycle through the ram's single read and write port. a
// result waiting in the output register does not stop the next item being accepted
// and worked on.
module sequential_list_engine #(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // index[6:0], value[38:7], zero pad
    input  logic [2:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // ok, data_out[32:1], position[38:33], length[45:39],
                                   // empty_res[46], zero pad
);

    localparam int AW = $clog2(DEPTH);

    logic                     start;
    logic                     core_idle;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata, ram_rdata;
    logic                     res_valid, res_ready;
    sle_pkg::sle_res_t        res;
    logic                     m_tvalid_reg;
    logic [47:0]              m_tdata_reg;

    assign s_tready  = core_idle;
    assign start     = s_tvalid && s_tready;
    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    sle_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sle_core #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .op        (s_tuser),
        .idx       (s_tdata[6:0]),
        .value     (s_tdata[38:7]),
        .idle      (core_idle),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {1'b0, res.empty_res, res.length, res.position,
                            res.data_out, res.ok};
        end
    end

endmodule

[bench/tb_sequential_list_engine.sv]
`timescale 1ns / 1ps

module tb_sequential_list_engine;

    localparam int           LIST_DEPTH = 64;
    localparam sle_pkg::op_t OP_SPARE   = 3'd7;

    typedef enum {FILL, DRAIN, CHURN} churn_mode_t;

    typedef struct {
        sle_pkg::op_t      op;
        logic [6:0]        idx;
        logic [31:0]       val;
        bit                fixed;
        sle_pkg::sle_res_t want;
    } list_step_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // index[6:0], value[38:7], zero pad
    logic [2:0]  s_tuser  = '0;    // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // ok, data_out[32:1], position[38:33], length[45:39],
                                   // empty_res[46], zero pad

    logic [31:0]       shadow_entries [LIST_DEPTH];
    int                shadow_count = 0;
    sle_pkg::sle_res_t awaited_results [$];
    sle_pkg::sle_res_t seen_result;
    sle_pkg::sle_res_t wanted_result;
    int                mismatches = 0;
    int                burst_left = 0;
    int                stall_cycles = 0;
    int                stall_style = 0;
    longint            cycle_count = 0;

    // ok, data_out, position, length, empty_res
    list_step_t directed_steps [25] = '{
        '{sle_pkg::OP_GET,    7'd0,   32'h0000_0000, 1'b1, {1'b0, 32'd0, 6'd0, 7'd0, 1'b1}},
        '{sle_pkg::OP_DELETE, 7'd0,   32'h0000_0000, 1'b1, {1'b0, 32'd0, 6'd0, 7'd0, 1'b1}},
        '{sle_pkg::OP_LOCATE, 7'd0,   32'h0000_0000, 1'b1, {1'b0, 32'd0, 6'd0, 7'd0, 1'b1}},
        '{sle_pkg::OP_PRIOR,  7'd0,   32'h0000_0000, 1'b1, {1'b0, 32'd0, 6'd0, 7'd0, 1'b1}},
        '{sle_pkg::OP_NEXT,   7'd0,   32'h0000_0000, 1'b1, {1'b0, 32'd0, 6'd0, 7'd0, 1'b1}},
        '{sle_pkg::OP_INSERT, 7'd1,   32'h0000_0005, 1'b1, {1'b0, 32'd0, 6'd0, 7'd0, 1'b1}},
        '{sle_pkg::OP_INSERT, 7'd0,   32'h8000_0000, 1'b1, {1'b1, 32'd0, 6'd0, 7'd1, 1'b0}},
        '{sle_pkg::OP_INSERT, 7'd1,   32'h7fff_ffff, 1'b1, {1'b1, 32'd0, 6'd0, 7'd2, 1'b0}},
        '{sle_pkg::OP_INSERT, 7'd0,   32'h0000_0000, 1'b0, '0},
        '{sle_pkg::OP_INSERT, 7'd3,   32'hffff_ffff, 1'b0, '0},
        '{sle_pkg::OP_INSERT, 7'd2,   32'h0000_0000, 1'b0, '0},
        '{sle_pkg::OP_GET,    7'd3,   32'h0000_0000, 1'b0, '0},
        '{sle_pkg::OP_GET,    7'd5,   32'h0000_0000, 1'b1, {1'b0, 32'd0, 6'd0, 7'd5, 1'b0}},
        '{sle_pkg::OP_LOCATE, 7'd0,   32'h0000_0000, 1'b0, '0},
        '{sle_pkg::OP_LOCATE, 7'd0,   32'h7fff_ffff, 1'b0, '0},
        '{sle_pkg::OP_LOCATE, 7'd0,   32'h1234_5678, 1'b0, '0},
        '{sle_pkg::OP_PRIOR,  7'd0,   32'h0000_0000, 1'b0, '0},
        '{sle_pkg::OP_PRIOR,  7'd0,   32'hffff_ffff, 1'b0, '0},
        '{sle_pkg::OP_NEXT,   7'd0,   32'hffff_ffff, 1'b0, '0},
        '{sle_pkg::OP_NEXT,   7'd0,   32'h8000_0000, 1'b0, '0},
        '{OP_SPARE,           7'd127, 32'hffff_ffff, 1'b1, {1'b0, 32'd0, 6'd0, 7'd5, 1'b0}},
        '{sle_pkg::OP_DELETE, 7'd127, 32'h0000_0000, 1'b1, {1'b0, 32'd0, 6'd0, 7'd5, 1'b0}},
        '{sle_pkg::OP_DELETE, 7'd4,   32'h0000_0000, 1'b0, '0},
        '{sle_pkg::OP_DELETE, 7'd0,   32'h0000_0000, 1'b0, '0},
        '{sle_pkg::OP_CLEAR,  7'd0,   32'h0000_0000, 1'b1, {1'b1, 32'd0, 6'd0, 7'd0, 1'b1}}
    };

    sequential_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic sle_pkg::sle_res_t apply_list_request(sle_pkg::op_t op,
                                                             logic [6:0] idx,
                                                             logic [31:0] val);
        sle_pkg::sle_res_t r;
        int                hit;
        int                at;
        r   = '0;
        hit = -1;
        at  = int'(idx);
        for (int k = shadow_count - 1; k >= 0; k--) begin
            if (shadow_entries[k] == val) hit = k;
        end
        case (op)
            sle_pkg::OP_CLEAR: begin
                shadow_count = 0;
                r.ok = 1'b1;
            end
            sle_pkg::OP_INSERT: begin
                if (shadow_count < LIST_DEPTH && at <= shadow_count) begin
                    for (int k = shadow_count; k > at; k--)
                        shadow_entries[k] = shadow_entries[k - 1];
                    shadow_entries[at] = val;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            sle_pkg::OP_DELETE: begin
                if (at < shadow_count) begin
                    r.data_out = shadow_entries[at];
                    for (int k = at + 1; k < shadow_count; k++)
                        shadow_entries[k - 1] = shadow_entries[k];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            sle_pkg::OP_GET: begin
                if (at < shadow_count) begin
                    r.data_out = shadow_entries[at];
                    r.ok = 1'b1;
                end
            end
            sle_pkg::OP_LOCATE: begin
                if (hit >= 0) begin
                    r.position = hit[5:0];
                    r.ok = 1'b1;
                end
            end
            sle_pkg::OP_PRIOR: begin
                if (hit > 0) begin
                    r.data_out = shadow_entries[hit - 1];
                    r.ok = 1'b1;
                end
            end
            sle_pkg::OP_NEXT: begin
                if (hit >= 0 && hit + 1 < shadow_count) begin
                    r.data_out = shadow_entries[hit + 1];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.length    = shadow_count[6:0];
        r.empty_res = (shadow_count == 0);
        return r;
    endfunction

    task automatic send_request(input sle_pkg::op_t op, input logic [6:0] idx,
                                input logic [31:0] val, input bit fixed,
                                input sle_pkg::sle_res_t want);
        sle_pkg::sle_res_t predicted;
        int                gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = int'($urandom_range(1, 30));
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_list_request(op, idx, val);
        awaited_results.push_back(fixed ? want : predicted);
    endtask

    // receiver back-pressure in one of four styles, picked at random
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) stall_style <= int'($urandom_range(0, 3));
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 9) < 4);
            default: begin
                if (stall_cycles > 0) begin
                    m_tready     <= 1'b0;
                    stall_cycles <= stall_cycles - 1;
                end else begin
                    m_tready     <= 1'b1;
                    stall_cycles <= ($urandom_range(0, 3) == 0)
                                  ? int'($urandom_range(1, 15)) : 0;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.ok        = m_tdata[0];
            seen_result.data_out  = m_tdata[32:1];
            seen_result.position  = m_tdata[38:33];
            seen_result.length    = m_tdata[45:39];
            seen_result.empty_res = m_tdata[46];
            if (awaited_results.size() == 0) begin
                if (mismatches < 10) $display("unexpected result item %h", m_tdata);
                mismatches++;
            end else begin
                wanted_result = awaited_results.pop_front();
                if (seen_result.ok !== wanted_result.ok
                        || seen_result.data_out !== wanted_result.data_out
                        || seen_result.position !== wanted_result.position
                        || seen_result.length !== wanted_result.length
                        || seen_result.empty_res !== wanted_result.empty_res) begin
                    if (mismatches < 10)
                        $display("mismatch: expected ok %b data %h pos %0d len %0d empty %b, %s",
                                 wanted_result.ok, wanted_result.data_out,
                                 wanted_result.position, wanted_result.length,
                                 wanted_result.empty_res,
                                 $sformatf("got ok %b data %h pos %0d len %0d empty %b",
                                           seen_result.ok, seen_result.data_out,
                                           seen_result.position, seen_result.length,
                                           seen_result.empty_res));
                    mismatches++;
                end
            end
        end
    end

    initial begin
        sle_pkg::op_t op;
        logic [6:0]   idx;
        logic [31:0]  val;
        churn_mode_t  mode;
        int           mode_left;
        int           r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_steps[i])
            send_request(directed_steps[i].op, directed_steps[i].idx, directed_steps[i].val,
                         directed_steps[i].fixed, directed_steps[i].want);
        mode      = FILL;
        mode_left = 200;
        repeat (1675) begin
            if (mode_left == 0) begin
                mode      = churn_mode_t'($urandom_range(0, 2));
                mode_left = int'($urandom_range(40, 160));
            end
            mode_left--;
            r = int'($urandom_range(0, 99));
            case (mode)
                FILL:
                    op = r < 70 ? sle_pkg::OP_INSERT : r < 76 ? sle_pkg::OP_DELETE :
                         r < 82 ? sle_pkg::OP_GET    : r < 88 ? sle_pkg::OP_LOCATE :
                         r < 93 ? sle_pkg::OP_PRIOR  : r < 98 ? sle_pkg::OP_NEXT : OP_SPARE;
                DRAIN:
                    op = r < 15 ? sle_pkg::OP_INSERT : r < 60 ? sle_pkg::OP_DELETE :
                         r < 70 ? sle_pkg::OP_GET    : r < 78 ? sle_pkg::OP_LOCATE :
                         r < 86 ? sle_pkg::OP_PRIOR  : r < 95 ? sle_pkg::OP_NEXT :
                         r < 98 ? sle_pkg::OP_CLEAR  : OP_SPARE;
                default:
                    op = r < 2  ? sle_pkg::OP_CLEAR  : r < 35 ? sle_pkg::OP_INSERT :
                         r < 55 ? sle_pkg::OP_DELETE : r < 67 ? sle_pkg::OP_GET :
                         r < 78 ? sle_pkg::OP_LOCATE : r < 88 ? sle_pkg::OP_PRIOR :
                         r < 98 ? sle_pkg::OP_NEXT   : OP_SPARE;
            endcase
            r = int'($urandom_range(0, 99));
            if (r < 85)      idx = 7'($urandom_range(0, shadow_count));
            else if (r < 95) idx = 7'($urandom_range(0, 64));
            else             idx = 7'($urandom_range(0, 127));
            // half the values already held, so searches hit and duplicates appear
            r = int'($urandom_range(0, 99));
            if (shadow_count > 0 && r < 50)
                val = shadow_entries[$urandom_range(0, shadow_count - 1)];
            else if (r < 54) val = 32'h8000_0000;
            else if (r < 58) val = 32'h7fff_ffff;
            else if (r < 60) val = 32'h0000_0000;
            else if (r < 62) val = 32'hffff_ffff;
            else             val = $urandom;
            send_request(op, idx, val, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
sv/sle_pkg.sv
sv/sle_ram.sv
sv/sle_core.sv
sv/sequential_list_engine.sv
bench/tb_sequential_list_engine.sv
